/* sv/rsc_pkg.sv */
// ============================================================================
// rsc_pkg
// Shared constants, types and helper functions of the radix string converter.
// ============================================================================
`default_nettype none

package rsc_pkg;

  localparam int MAX_BASE   = 16;
  localparam int VALUE_BITS = 32;

  localparam int SYM_W      = 8;
  localparam int LEN_W      = 5;
  localparam int ALPHA_W    = 64;
  localparam int NUM_SYMS   = 2 * ALPHA_W / SYM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int BASE_W     = $clog2(MAX_BASE + 1);
  localparam int DIGIT_W    = $clog2(NUM_SYMS);
  localparam int REM2_W     = DIGIT_W + 1;
  localparam int SCORE_W    = $clog2(MAX_BASE * (MAX_BASE - 1) / 2 + 1);
  localparam int BITCNT_W   = $clog2(VALUE_BITS);
  localparam int DIDX_W     = $clog2(VALUE_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_FROM_ALPHA_LO = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FROM_ALPHA_HI = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FROM_LEN      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TO_ALPHA_LO   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_TO_ALPHA_HI   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TO_LEN        = CFG_IDX_W'(5);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2);

  typedef logic [2*ALPHA_W-1:0] alpha_t;

  typedef struct packed {
    logic en;
    logic clear;
  } rsc_mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rsc_div_stat_t;

  function automatic logic [SYM_W-1:0] sym_at(alpha_t alpha, logic [DIGIT_W-1:0] k);
    return alpha[k*SYM_W +: SYM_W];
  endfunction

  function automatic logic [BASE_W-1:0] clamp_base(logic [LEN_W-1:0] len,
                                                   logic [BASE_W-1:0] floor_val);
    logic [BASE_W-1:0] res;
    if (len > LEN_W'(MAX_BASE)) begin
      res = BASE_W'(MAX_BASE);
    end else if (BASE_W'(len) < floor_val) begin
      res = floor_val;
    end else begin
      res = BASE_W'(len);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/rsc_sym_if.sv */
// ============================================================================
// rsc_sym_if
// Valid/ready channel that carries one symbol and a last flag per transfer.
// ============================================================================
`default_nettype none

interface rsc_sym_if import rsc_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);

endinterface

`default_nettype wire

/* sv/rsc_mac.sv */
// ============================================================================
// rsc_mac
// Scores a source symbol against the source alphabet and folds it into the
// accumulated value with one multiply-add.
// ============================================================================
`default_nettype none

module rsc_mac import rsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rsc_mac_ctl_t          ctl,
  input  wire logic [SYM_W-1:0]      symbol,
  input  wire alpha_t                from_alpha,
  input  wire logic [LEN_W-1:0]      from_len,
  output logic [VALUE_BITS-1:0]      acc
);

  logic [VALUE_BITS-1:0]        acc_r;
  logic [VALUE_BITS-1:0]        acc_nxt;
  logic [BASE_W-1:0]            fb;
  logic [SCORE_W-1:0]           score;
  logic [VALUE_BITS+BASE_W-1:0] prod;

  assign fb = clamp_base(from_len, BASE_W'(0));

  always_comb begin
    score = '0;
    for (int k = 0; k < MAX_BASE; k++) begin
      if ((BASE_W'(k) < fb) && (sym_at(from_alpha, DIGIT_W'(k)) == symbol)) begin
        score = score + SCORE_W'(k);
      end
    end
  end

  assign prod = {{BASE_W{1'b0}}, acc_r} * {{VALUE_BITS{1'b0}}, fb};

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.en) begin
      if (fb >= BASE_W'(2)) begin
        acc_nxt = prod[VALUE_BITS-1:0] + VALUE_BITS'(score);
      end else begin
        acc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

/* sv/rsc_div.sv */
// ============================================================================
// rsc_div
// Bit-serial restoring divider: divides the value by the target base, one
// quotient bit per cycle.
// ============================================================================
`default_nettype none

module rsc_div import rsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [BASE_W-1:0]     divisor,
  output rsc_div_stat_t              stat,
  output logic [VALUE_BITS-1:0]      quotient,
  output logic [DIGIT_W-1:0]         remainder
);

  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0]    r_r, r_nxt;
  logic [BITCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [REM2_W-1:0]     r2;
  logic [REM2_W-1:0]     dsr;
  logic                  ge;

  assign r2  = {r_r, q_r[VALUE_BITS-1]};
  assign dsr = REM2_W'(divisor);
  assign ge  = (r2 >= dsr);

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[VALUE_BITS-2:0], ge};
      r_nxt   = ge ? DIGIT_W'(r2 - dsr) : DIGIT_W'(r2);
      cnt_nxt = cnt_r + BITCNT_W'(1);
      if (cnt_r == BITCNT_W'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;
  assign remainder = r_r;

endmodule

`default_nettype wire

/* sv/radix_string_converter.sv */
// Steps: a non-final symbol is accumulated in the MAC state, then the input is
// ready again. A final symbol is accumulated, then each output digit is made in
// the DIVS and DIVW states by the 32-step bit-serial divider, then the digits go out.
// Throughput: one input item at a time; the input is not ready meanwhile.
// Reset is synchronous and active low; it clears control state, the value,
// the alphabets (to zero) and sets both lengths to two.
// ============================================================================
// radix_string_converter
// Converts a number string from a source digit alphabet to a target one.
// ============================================================================
`default_nettype none

module radix_string_converter import rsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rsc_sym_if.sink                    in_ch,
  rsc_sym_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_DIVS = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [ALPHA_W-1:0] from_lo_r, from_hi_r, to_lo_r, to_hi_r;
  logic [LEN_W-1:0]   from_len_r, to_len_r;

  logic [2:0]          state_r, state_nxt;
  logic [SYM_W-1:0]    sym_r;
  logic                last_r;
  logic                first_r, first_nxt;
  logic [DIDX_W-1:0]   dcnt_r, dcnt_nxt;
  logic [DIDX_W-1:0]   emit_idx_r, emit_idx_nxt;
  logic [DIGIT_W-1:0]  digit_buf [VALUE_BITS];
  logic                digit_we;

  logic                out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]    out_sym_r;
  logic                out_last_r, out_last_nxt;
  logic                load_out;

  rsc_mac_ctl_t          mac_ctl;
  logic [VALUE_BITS-1:0] acc;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  rsc_div_stat_t         div_stat;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;
  logic [BASE_W-1:0]     tb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_lo_r  <= '0;
      from_hi_r  <= '0;
      from_len_r <= LEN_RESET;
      to_lo_r    <= '0;
      to_hi_r    <= '0;
      to_len_r   <= LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FROM_ALPHA_LO: from_lo_r  <= cfg_data[ALPHA_W-1:0];
        REG_FROM_ALPHA_HI: from_hi_r  <= cfg_data[ALPHA_W-1:0];
        REG_FROM_LEN:      from_len_r <= cfg_data[LEN_W-1:0];
        REG_TO_ALPHA_LO:   to_lo_r    <= cfg_data[ALPHA_W-1:0];
        REG_TO_ALPHA_HI:   to_hi_r    <= cfg_data[ALPHA_W-1:0];
        REG_TO_LEN:        to_len_r   <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign tb = clamp_base(to_len_r, BASE_W'(2));

  rsc_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .symbol     (sym_r),
    .from_alpha ({from_hi_r, from_lo_r}),
    .from_len   (from_len_r),
    .acc        (acc)
  );

  rsc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (tb),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign in_ch.ready   = (state_r == S_IDLE);
  assign mac_ctl.en    = (state_r == S_MAC);
  assign mac_ctl.clear = (state_r == S_DIVS) && first_r;
  assign div_start     = (state_r == S_DIVS);
  assign div_dividend  = first_r ? acc : div_quot;
  assign digit_we      = (state_r == S_DIVW) && div_stat.done;
  assign load_out      = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt    = state_r;
    first_nxt    = first_r;
    dcnt_nxt     = dcnt_r;
    emit_idx_nxt = emit_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (last_r) begin
          state_nxt = S_DIVS;
          first_nxt = 1'b1;
          dcnt_nxt  = '0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIVS: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_stat.done) begin
          first_nxt = 1'b0;
          if (div_quot == '0) begin
            state_nxt    = S_EMIT;
            emit_idx_nxt = dcnt_r;
          end else begin
            state_nxt = S_DIVS;
            dcnt_nxt  = dcnt_r + DIDX_W'(1);
          end
        end
      end
      S_EMIT: begin
        if (load_out) begin
          if (emit_idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r - DIDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_last_nxt  = out_last_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = (emit_idx_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b0;
      dcnt_r      <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      dcnt_r      <= dcnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sym_r  <= in_ch.symbol;
      last_r <= in_ch.last;
    end
    if (digit_we) begin
      digit_buf[dcnt_r] <= div_rem;
    end
    if (load_out) begin
      out_sym_r <= sym_at({to_hi_r, to_lo_r}, digit_buf[emit_idx_r]);
    end
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.symbol = out_sym_r;
  assign out_ch.last   = out_last_r;

endmodule

`default_nettype wire

/* tb/tb_radix_string_converter.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_radix_string_converter
// Self-checking testbench for the radix string converter. Strings of source
// symbols are sent over the input channel under several alphabet and base
// settings. A behavioral model of the conversion predicts every output digit,
// and each digit transfer is compared with the oldest prediction. Both sides
// of the data path idle at random, and the receiver holds off once for a long
// stretch so that the block has to stall its input.
// ============================================================================

module tb_radix_string_converter;
  import rsc_pkg::*;

  localparam int          RANDOM_ITEMS    = 160;
  localparam int          PHASE_ITEMS     = 20;
  localparam int          HOLD_OFF_CYCLES = 600;
  localparam int          WATCHDOG_LIMIT  = 20000;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          DRAIN_CYCLES    = 1200;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } digit_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rsc_sym_if in_ch ();
  rsc_sym_if out_ch ();

  radix_string_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's registers and running value.
  logic [2*ALPHA_W-1:0]  src_alpha;
  logic [LEN_W-1:0]      src_len;
  logic [2*ALPHA_W-1:0]  dst_alpha;
  logic [LEN_W-1:0]      dst_len;
  logic [VALUE_BITS-1:0] acc_value;

  digit_t expected_digits[$];
  int     error_count;
  bit     in_idle_on;
  bit     out_idle_on;
  bit     hold_off_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [2*ALPHA_W-1:0] ascii_alpha(string s);
    logic [2*ALPHA_W-1:0] a;
    a = '0;
    for (int k = 0; k < s.len() && k < NUM_SYMS; k++) begin
      a[8*k +: 8] = s[k];
    end
    return a;
  endfunction

  task automatic convert_symbol(input logic [SYM_W-1:0] sym, input logic fin);
    int unsigned     src_base;
    int unsigned     dst_base;
    int unsigned     score;
    longint unsigned n;
    longint unsigned div;
    longint unsigned d;
    digit_t          dig;
    src_base = (src_len > MAX_BASE) ? MAX_BASE : src_len;
    if (src_base >= 2) begin
      score = 0;
      for (int k = 0; k < src_base; k++) begin
        if (src_alpha[8*k +: 8] == sym) score += k;
      end
      n = acc_value;
      n = n * src_base + score;
      acc_value = n[VALUE_BITS-1:0];
    end else begin
      acc_value = '0;
    end
    if (fin) begin
      dst_base = (dst_len > MAX_BASE) ? MAX_BASE : (dst_len < 2) ? 2 : dst_len;
      n = acc_value;
      div = 1;
      while (div <= n / dst_base) div *= dst_base;
      while (div > 0) begin
        d = n / div;
        n -= d * div;
        div /= dst_base;
        dig.symbol = dst_alpha[8*int'(d & 15) +: 8];
        dig.last = (div == 0);
        expected_digits.push_back(dig);
      end
      acc_value = '0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_FROM_ALPHA_LO: src_alpha[ALPHA_W-1:0]         = data;
      REG_FROM_ALPHA_HI: src_alpha[2*ALPHA_W-1:ALPHA_W] = data;
      REG_FROM_LEN:      src_len                        = data[LEN_W-1:0];
      REG_TO_ALPHA_LO:   dst_alpha[ALPHA_W-1:0]         = data;
      REG_TO_ALPHA_HI:   dst_alpha[2*ALPHA_W-1:ALPHA_W] = data;
      REG_TO_LEN:        dst_len                        = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [2*ALPHA_W-1:0] from_a, input logic [CFG_DATA_W-1:0] from_l,
                           input logic [2*ALPHA_W-1:0] to_a, input logic [CFG_DATA_W-1:0] to_l);
    write_reg(REG_FROM_ALPHA_LO, from_a[ALPHA_W-1:0]);
    write_reg(REG_FROM_ALPHA_HI, from_a[2*ALPHA_W-1:ALPHA_W]);
    write_reg(REG_FROM_LEN, from_l);
    write_reg(REG_TO_ALPHA_LO, to_a[ALPHA_W-1:0]);
    write_reg(REG_TO_ALPHA_HI, to_a[2*ALPHA_W-1:ALPHA_W]);
    write_reg(REG_TO_LEN, to_l);
  endtask

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic fin);
    int unsigned gap;
    gap = pick_gap(in_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.symbol <= sym;
    in_ch.last   <= fin;
    do @(posedge clk); while (!in_ch.ready);
    convert_symbol(sym, fin);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_symbol(s[i], i == s.len() - 1);
    end
  endtask

  task automatic wait_for_drain(int settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // After reset both alphabets are all zero bytes, so a zero symbol matches
  // both source entries and scores one.
  task automatic test_reset_values();
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b1);
    send_symbol(8'h00, 1'b1);
    wait_for_drain(SETTLE_CYCLES);
  endtask

  task automatic test_special_cases();
    configure(ascii_alpha("0123456789ABCDEF"), CFG_DATA_W'(16),
              ascii_alpha("0123456789abcdef"), CFG_DATA_W'(16));
    send_string("0");
    wait_for_drain(SETTLE_CYCLES);
    write_reg(REG_TO_LEN, CFG_DATA_W'(2));
    // Nine hex digits wrap to the largest value, which needs 32 binary digits.
    send_string("1FFFFFFFF");
    wait_for_drain(SETTLE_CYCLES);
    write_reg(REG_FROM_LEN, CFG_DATA_W'(0));
    send_string("Z");
    wait_for_drain(SETTLE_CYCLES);
    write_reg(REG_FROM_LEN, CFG_DATA_W'(1));
    send_string("7");
    wait_for_drain(SETTLE_CYCLES);
    write_reg(REG_FROM_LEN, CFG_DATA_W'(31));
    send_string("A");
    wait_for_drain(SETTLE_CYCLES);
    write_reg(REG_TO_LEN, CFG_DATA_W'(0));
    send_string("5");
    wait_for_drain(SETTLE_CYCLES);
    write_reg(REG_TO_LEN, CFG_DATA_W'(1));
    send_string("5");
    wait_for_drain(SETTLE_CYCLES);
    write_reg(REG_TO_LEN, CFG_DATA_W'(31));
    send_string("FF");
    wait_for_drain(SETTLE_CYCLES);
  endtask

  task automatic test_output_hold_off();
    configure(ascii_alpha("0123456789"), CFG_DATA_W'(10),
              ascii_alpha("0123456789ABCDEF"), CFG_DATA_W'(16));
    in_idle_on = 1'b0;
    hold_off_req = 1'b1;
    send_string("42");
    send_string("1234");
    send_string("987654");
    wait_for_drain(SETTLE_CYCLES);
  endtask

  task automatic test_random_strings();
    int unsigned          items;
    int unsigned          phase_items;
    int unsigned          str_len;
    int unsigned          base;
    int unsigned          from_l;
    int unsigned          to_l;
    int unsigned          r;
    logic [2*ALPHA_W-1:0] from_a;
    logic [2*ALPHA_W-1:0] to_a;
    logic [SYM_W-1:0]     sym;
    items = 0;
    for (int phase = 0; items < RANDOM_ITEMS; phase++) begin
      from_a = {$urandom, $urandom, $urandom, $urandom};
      to_a   = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 2) == 0) from_a[8*$urandom_range(1, 15) +: 8] = from_a[7:0];
      r = $urandom_range(0, 9);
      from_l = (r == 0) ? $urandom_range(0, 1) : (r == 1) ? $urandom_range(17, 31)
             : $urandom_range(2, 16);
      r = $urandom_range(0, 9);
      to_l = (r == 0) ? $urandom_range(0, 1) : (r == 1) ? $urandom_range(17, 31)
           : $urandom_range(2, 16);
      if (phase == 0) begin
        from_l = 16;
        to_l = 2;
      end else if (phase == 1) begin
        from_l = 2;
        to_l = 16;
      end
      configure(from_a, {$urandom, 27'($urandom), 5'(from_l)},
                to_a, {$urandom, 27'($urandom), 5'(to_l)});
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      base = (src_len > MAX_BASE) ? MAX_BASE : (src_len < 1) ? 1 : src_len;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        str_len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
        for (int i = 0; i < str_len; i++) begin
          if ($urandom_range(0, 99) < 85) begin
            sym = src_alpha[8*$urandom_range(0, base - 1) +: 8];
          end else begin
            sym = SYM_W'($urandom_range(0, 255));
          end
          send_symbol(sym, i == str_len - 1);
        end
        phase_items += str_len;
      end
      items += phase_items;
      wait_for_drain(SETTLE_CYCLES);
    end
  endtask

  // Result side: random ready gaps plus one long requested hold-off.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap(out_idle_on);
      end
    end
  end

  always @(posedge clk) begin
    digit_t exp_dig;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected digit transfer: symbol %02h last %0b",
                 $time, out_ch.symbol, out_ch.last);
        error_count++;
      end else begin
        exp_dig = expected_digits.pop_front();
        if (out_ch.symbol !== exp_dig.symbol || out_ch.last !== exp_dig.last) begin
          $display("%0t: digit mismatch: expected symbol %02h last %0b, got symbol %02h last %0b",
                   $time, exp_dig.symbol, exp_dig.last, out_ch.symbol, out_ch.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("radix_string_converter test failed");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.symbol = '0;
    in_ch.last   = 1'b0;
    src_alpha    = '0;
    src_len      = LEN_RESET;
    dst_alpha    = '0;
    dst_len      = LEN_RESET;
    acc_value    = '0;
    error_count  = 0;
    in_idle_on   = 1'b1;
    out_idle_on  = 1'b1;
    hold_off_req = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_special_cases();
    test_output_hold_off();
    test_random_strings();

    wait_for_drain(DRAIN_CYCLES);
    if (expected_digits.size() != 0) begin
      $display("%0t: %0d expected digits never arrived", $time, expected_digits.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("radix_string_converter test passed");
    end else begin
      $display("radix_string_converter test failed");
    end
    $finish;
  end

endmodule

/* radix_string_converter.f */
sv/rsc_pkg.sv
sv/rsc_sym_if.sv
sv/rsc_mac.sv
sv/rsc_div.sv
sv/radix_string_converter.sv
tb/tb_radix_string_converter.sv
